// ===== hdl/clu_pkg.sv =====
// Shared types and operation codes of the console line unit.
package clu_pkg;

    typedef enum logic [3:0] {
        OP_POLL    = 4'd0,
        OP_PUSH_RX = 4'd1,
        OP_RD_RXCS = 4'd2,
        OP_WR_RXCS = 4'd3,
        OP_RD_RXDB = 4'd4,
        OP_RD_TXCS = 4'd5,
        OP_WR_TXCS = 4'd6,
        OP_WR_TXDB = 4'd7,
        OP_ACK_RX  = 4'd8,
        OP_ACK_TX  = 4'd9
    } t_op;

    localparam int unsigned IE_BIT = 6;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] wdata;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_rx;
        logic       irq_tx;
        logic       rx_dropped;
    } t_out_item;

endpackage

// ===== hdl/clu_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module clu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q0;
    logic [WIDTH-1:0] r_q1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q0 <= r_mem[i_raddr0];
        r_q1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_q0;
    assign o_rdata1 = r_q1;

endmodule

// ===== hdl/clu_exec.sv =====
// Register file and per-beat execution logic of the console line unit.
module clu_exec #(
    parameter int FIFO_DEPTH = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  clu_pkg::t_in_item             i_item,
    input  logic [7:0]                    i_d0,
    input  logic [7:0]                    i_d1,
    output clu_pkg::t_out_item            o_result,
    output logic                          o_wr_en,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_wr_addr,
    output logic [7:0]                    o_wr_data,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_rd_addr0,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_rd_addr1
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH);

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == LAST) ? '0 : a + 1'b1;
    endfunction

    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [7:0]    r_rx_data, n_rx_data;
    logic          r_rx_done, n_rx_done;
    logic          r_rx_en, n_rx_en;
    logic          r_tx_en, n_tx_en;
    logic          r_rx_latch, n_rx_latch;
    logic          r_tx_latch, n_tx_latch;
    logic          push_ok;
    logic          loaded;
    logic          ie;
    logic [AW-1:0] nxt_head;

    assign ie = i_item.wdata[clu_pkg::IE_BIT];

    always_comb begin
        n_count    = r_count;
        n_head     = r_head;
        n_tail     = r_tail;
        n_rx_data  = r_rx_data;
        n_rx_done  = r_rx_done;
        n_rx_en    = r_rx_en;
        n_tx_en    = r_tx_en;
        n_rx_latch = r_rx_latch;
        n_tx_latch = r_tx_latch;
        push_ok    = 1'b0;
        loaded     = 1'b0;
        o_result   = '0;

        // Poll and both receive reads first move a waiting byte into the data register.
        if ((i_item.op == clu_pkg::OP_POLL || i_item.op == clu_pkg::OP_RD_RXCS ||
             i_item.op == clu_pkg::OP_RD_RXDB) && !r_rx_done && r_count != '0) begin
            n_rx_data  = i_d0;
            n_head     = f_inc(r_head);
            n_count    = r_count - 1'b1;
            n_rx_done  = 1'b1;
            n_rx_latch = r_rx_en;
            loaded     = 1'b1;
        end

        unique case (i_item.op)
            clu_pkg::OP_POLL: begin
            end
            clu_pkg::OP_PUSH_RX: begin
                if (r_count == FULL) begin
                    o_result.rx_dropped = 1'b1;
                end else begin
                    push_ok = 1'b1;
                    n_tail  = f_inc(r_tail);
                    n_count = r_count + 1'b1;
                end
            end
            clu_pkg::OP_RD_RXCS: begin
                o_result.rdata = {n_rx_done, r_rx_en, 6'b0};
            end
            clu_pkg::OP_WR_RXCS: begin
                n_rx_en = ie;
                if (r_rx_done && ie && !r_rx_en) begin
                    n_rx_latch = 1'b1;
                end
                if (!(r_rx_done && ie)) begin
                    n_rx_latch = 1'b0;
                end
            end
            clu_pkg::OP_RD_RXDB: begin
                o_result.rdata = n_rx_data;
                if (n_rx_done) begin
                    n_rx_done  = 1'b0;
                    n_rx_latch = 1'b0;
                    // Prefetch: the next byte sits one entry past a byte just loaded.
                    if (n_count != '0) begin
                        n_rx_data  = loaded ? i_d1 : i_d0;
                        n_head     = f_inc(n_head);
                        n_count    = n_count - 1'b1;
                        n_rx_done  = 1'b1;
                        n_rx_latch = r_rx_en;
                    end
                end
            end
            clu_pkg::OP_RD_TXCS: begin
                o_result.rdata = {1'b1, r_tx_en, 6'b0};
            end
            clu_pkg::OP_WR_TXCS: begin
                n_tx_en = ie;
                if (ie && !r_tx_en) begin
                    n_tx_latch = 1'b1;
                end
                if (!ie) begin
                    n_tx_latch = 1'b0;
                end
            end
            clu_pkg::OP_WR_TXDB: begin
                o_result.tx_valid = 1'b1;
                o_result.tx_byte  = i_item.wdata;
                n_tx_latch        = r_tx_en;
            end
            clu_pkg::OP_ACK_RX: begin
                n_rx_latch = r_rx_done && r_rx_en;
            end
            clu_pkg::OP_ACK_TX: begin
                n_tx_latch = 1'b0;
            end
            default: begin
            end
        endcase

        o_result.irq_rx = n_rx_latch || (n_rx_done && n_rx_en);
        o_result.irq_tx = n_tx_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_rx_data  <= '0;
            r_rx_done  <= 1'b0;
            r_rx_en    <= 1'b0;
            r_tx_en    <= 1'b0;
            r_rx_latch <= 1'b0;
            r_tx_latch <= 1'b0;
        end else if (i_fire) begin
            r_count    <= n_count;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_rx_data  <= n_rx_data;
            r_rx_done  <= n_rx_done;
            r_rx_en    <= n_rx_en;
            r_tx_en    <= n_tx_en;
            r_rx_latch <= n_rx_latch;
            r_tx_latch <= n_tx_latch;
        end
    end

    // The memory keeps reading the head and the entry after it for the next beat.
    assign nxt_head   = i_fire ? n_head : r_head;
    assign o_rd_addr0 = nxt_head;
    assign o_rd_addr1 = f_inc(nxt_head);
    assign o_wr_en    = i_fire && push_ok;
    assign o_wr_addr  = r_tail;
    assign o_wr_data  = i_item.rx_byte;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("receive queue count exceeds its depth");

    a_empty_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FULL) |-> (r_head == r_tail))
        else $error("queue pointers disagree with an empty or full count");

    a_load_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !r_rx_done && r_count != '0 &&
         (i_item.op == clu_pkg::OP_POLL || i_item.op == clu_pkg::OP_RD_RXCS))
        |=> (r_rx_done && $past(r_count) == r_count + 1'b1))
        else $error("a load from the queue did not set DONE and pop one byte");

endmodule

// ===== hdl/console_line_unit_with_irq_latch_core.sv =====
// Top level of the console line unit: beat staging, receive queue memory and result register.
//
// A beat is taken in every cycle while the result register is empty or being drained; it
// executes once the result register is empty or being drained, and its result is offered
// from the cycle after execution. The receive queue lives in a dual-read memory that is read
// continuously at the queue head and the entry behind it, so a receive-data read and its
// prefetch finish in the same execute cycle; a write into an entry being read in the same
// cycle is forwarded. Receive and transmit interrupt requests are reported with every result.
module console_line_unit_with_irq_latch_core #(
    parameter int FIFO_DEPTH = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  clu_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output clu_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(FIFO_DEPTH);

    logic               r_ex_valid;
    clu_pkg::t_in_item  r_ex_item;
    logic               r_out_valid;
    clu_pkg::t_out_item r_out_data;
    logic               ex_fire;
    clu_pkg::t_out_item result;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic [AW-1:0]      rd_addr0;
    logic [AW-1:0]      rd_addr1;
    logic [7:0]         q0;
    logic [7:0]         q1;
    logic               r_fwd0;
    logic               r_fwd1;
    logic [7:0]         r_fwd_data;

    assign ex_fire    = r_ex_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_ex_valid || ex_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd0      <= 1'b0;
            r_fwd1      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_ex_valid <= i_in_valid;
            end
            if (ex_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_fwd0 <= wr_en && (wr_addr == rd_addr0);
            r_fwd1 <= wr_en && (wr_addr == rd_addr1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ex_item <= i_in_data;
        end
        if (ex_fire) begin
            r_out_data <= result;
        end
        r_fwd_data <= wr_data;
    end

    clu_ram #(
        .WIDTH(8),
        .DEPTH(FIFO_DEPTH)
    ) u_rx_fifo (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr0(rd_addr0),
        .i_raddr1(rd_addr1),
        .o_rdata0(q0),
        .o_rdata1(q1)
    );

    clu_exec #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (ex_fire),
        .i_item    (r_ex_item),
        .i_d0      (r_fwd0 ? r_fwd_data : q0),
        .i_d1      (r_fwd1 ? r_fwd_data : q1),
        .o_result  (result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr0(rd_addr0),
        .o_rd_addr1(rd_addr1)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
